// ===== sv/srsp_pkg.sv =====
// Shared types, codes and constants for the snapshot record stream parser.
// No dependencies; imported by srsp_core and snapshot_record_stream_parser_top.
package srsp_pkg;

  // default width of the string length and element counters
  localparam int COUNT_BITS_DEF = 64;

  // parse phases
  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_OPCODE    = 4'd1,
    PH_LEN_FIRST = 4'd2,
    PH_LEN_MORE  = 4'd3,
    PH_STRING    = 4'd4,
    PH_EXPIRY    = 4'd5,
    PH_SCORE     = 4'd6,
    PH_TRAILER   = 4'd7,
    PH_HALT      = 4'd8
  } phase_t;

  // what a decoded length is used for
  typedef enum logic [1:0] {
    LP_DROP   = 2'd0,
    LP_STRING = 2'd1,
    LP_COUNT  = 2'd2
  } lpurp_t;

  // result event codes
  localparam logic [2:0] EV_BYTE    = 3'd0;
  localparam logic [2:0] EV_EMPTY   = 3'd1;
  localparam logic [2:0] EV_SCORE   = 3'd2;
  localparam logic [2:0] EV_REC_END = 3'd3;
  localparam logic [2:0] EV_DONE    = 3'd4;
  localparam logic [2:0] EV_ERROR   = 3'd5;

  // string roles
  localparam logic [2:0] ROLE_KEY    = 3'd0;
  localparam logic [2:0] ROLE_VALUE  = 3'd1;
  localparam logic [2:0] ROLE_LIST   = 3'd2;
  localparam logic [2:0] ROLE_HFIELD = 3'd3;
  localparam logic [2:0] ROLE_HVALUE = 3'd4;
  localparam logic [2:0] ROLE_MEMBER = 3'd5;

  // record kinds
  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_LIST   = 2'd1;
  localparam logic [1:0] KIND_HASH   = 2'd2;
  localparam logic [1:0] KIND_ZSET   = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_MAGIC  = 3'd1;
  localparam logic [2:0] ERR_LENGTH = 3'd2;
  localparam logic [2:0] ERR_TYPE   = 3'd3;
  localparam logic [2:0] ERR_TRUNC  = 3'd4;

  // opcodes and type bytes
  localparam logic [7:0] OP_EOF      = 8'hFF;
  localparam logic [7:0] OP_SELECTDB = 8'hFE;
  localparam logic [7:0] OP_EXPIRY   = 8'hFC;
  localparam logic [7:0] OP_T_STRING = 8'h00;
  localparam logic [7:0] OP_T_LIST   = 8'h01;
  localparam logic [7:0] OP_T_HASH   = 8'h04;
  localparam logic [7:0] OP_T_ZSET   = 8'h05;

  // length prefix codes
  localparam logic [7:0] LEN_32BIT   = 8'h80;
  localparam logic [7:0] LEN_64BIT   = 8'h81;
  localparam logic [7:0] LEN_LOW6    = 8'h3F;

  localparam logic [3:0] HEADER_LEN = 4'd9;
  localparam logic [3:0] MAGIC_LEN  = 4'd5;

  // one result transaction
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [2:0]  string_role;
    logic        string_last;
    logic        record_last;
    logic [1:0]  value_kind;
    logic [63:0] score_bits;
    logic        expiry_valid;
    logic [63:0] expiry_ms;
    logic [2:0]  error_code;
  } result_t;

  // ascii magic bytes of the header
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h52;
      3'd1:    val = 8'h45;
      3'd2:    val = 8'h44;
      3'd3:    val = 8'h49;
      3'd4:    val = 8'h53;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/snapshot_record_stream_parser_top.sv =====
// Snapshot record stream parser: input byte register, parser core, result register.
// Depends on srsp_pkg and srsp_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one stream byte per transaction
//   with stream_end marking the last byte; the parser restarts after it.
//   Output channel (out_valid / out_stall) carries zero or one result per byte:
//   string bytes tagged by role, empty strings, scores, record ends, file done
//   or an error code.
//   Path: a byte that gives a result passes the input register and then the
//   result register before it shows on the output.
//   Throughput: one byte per cycle unless a stalled result holds it; the parser core
//   decodes a byte in a single pass through its next-state logic, so a new byte
//   may follow every cycle. A byte with no result never waits on the output side.
//   Stall: while the result register holds a result that the receiver stalls,
//   a byte that would give a result waits in the input register and in_stall
//   is raised; a byte with no result still passes.
//   Reset (rst, synchronous) returns the parser to the header phase and empties
//   both registers.
module snapshot_record_stream_parser_top
  import srsp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [2:0]  string_role,
  output logic        string_last,
  output logic        record_last,
  output logic [1:0]  value_kind,
  output logic [63:0] score_bits,
  output logic        expiry_valid,
  output logic [63:0] expiry_ms,
  output logic [2:0]  error_code
);

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_end;
  logic       res_has;
  result_t    res;
  result_t    out_reg;
  logic       out_free;
  logic       fire;

  // handshake: core consumes a byte when it gives no result or its result has a place to go
  assign out_free = !out_valid || !out_stall;
  assign fire     = in_reg_valid && (!res_has || out_free);
  assign in_stall = in_reg_valid && !fire;

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= data_byte;
      in_reg_end  <= stream_end;
    end
  end

  // parser core
  srsp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (in_reg_byte),
    .stream_end (in_reg_end),
    .res_has    (res_has),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_has) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_has) begin
      out_reg <= res;
    end
  end

  // result fields
  assign event_res    = out_reg.event_res;
  assign payload_byte = out_reg.payload_byte;
  assign string_role  = out_reg.string_role;
  assign string_last  = out_reg.string_last;
  assign record_last  = out_reg.record_last;
  assign value_kind   = out_reg.value_kind;
  assign score_bits   = out_reg.score_bits;
  assign expiry_valid = out_reg.expiry_valid;
  assign expiry_ms    = out_reg.expiry_ms;
  assign error_code   = out_reg.error_code;

endmodule

// ===== sv/srsp_core.sv =====
// Parser state and per-byte decode logic for the snapshot record stream parser.
// Depends on srsp_pkg; instantiated by snapshot_record_stream_parser_top.
module srsp_core
  import srsp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        res_has,
  output result_t     res
);

  // state registers
  phase_t                  phase, phase_next;
  logic [3:0]              hdr_pos, hdr_pos_next;
  logic                    magic_ok, magic_ok_next;
  logic [3:0]              prefix_left, prefix_left_next;
  logic [63:0]             length_value, length_value_next;
  lpurp_t                  length_purpose, length_purpose_next;
  logic [COUNT_BITS-1:0]   str_left, str_left_next;
  logic [COUNT_BITS-1:0]   elem_left, elem_left_next;
  logic [1:0]              record_type, record_type_next;
  logic [2:0]              cur_role, cur_role_next;
  logic [2:0]              word_idx, word_idx_next;
  logic [63:0]             word_acc, word_acc_next;
  logic [63:0]             pend_exp, pend_exp_next;
  logic                    pend_exp_valid, pend_exp_valid_next;

  // next-state and result decode for one byte
  always_comb begin
    logic [63:0] lv_new;
    logic [63:0] acc_new;
    logic        len_done;
    logic        str_done;
    logic        elem_done;
    logic [2:0]  elem_role;
    logic        rec_end;
    logic        err_set;
    logic [2:0]  err_code;
    logic        was_halted;
    logic        too_wide;

    phase_next          = phase;
    hdr_pos_next        = hdr_pos;
    magic_ok_next       = magic_ok;
    prefix_left_next    = prefix_left;
    length_value_next   = length_value;
    length_purpose_next = length_purpose;
    str_left_next       = str_left;
    elem_left_next      = elem_left;
    record_type_next    = record_type;
    cur_role_next       = cur_role;
    word_idx_next       = word_idx;
    word_acc_next       = word_acc;
    pend_exp_next       = pend_exp;
    pend_exp_valid_next = pend_exp_valid;

    res        = '0;
    res_has    = 1'b0;
    lv_new     = length_value;
    len_done   = 1'b0;
    str_done   = 1'b0;
    elem_done  = 1'b0;
    elem_role  = ROLE_LIST;
    rec_end    = 1'b0;
    err_set    = 1'b0;
    err_code   = ERR_NONE;
    was_halted = 1'b0;

    // little-endian word with the current byte placed in its lane
    for (int i = 0; i < 8; i++) begin
      acc_new[8*i +: 8] = (word_idx == 3'(i)) ? data_byte : word_acc[8*i +: 8];
    end

    // main phase decode
    unique case (phase)
      PH_HEADER: begin
        if (hdr_pos < MAGIC_LEN && data_byte != magic_byte(hdr_pos[2:0])) begin
          magic_ok_next = 1'b0;
        end
        hdr_pos_next = hdr_pos + 4'd1;
        if (hdr_pos_next >= HEADER_LEN) begin
          if (!magic_ok_next) begin
            err_set  = 1'b1;
            err_code = ERR_MAGIC;
          end else begin
            phase_next = PH_OPCODE;
          end
        end
      end
      PH_OPCODE: begin
        unique case (data_byte)
          OP_EOF: begin
            word_idx_next = 3'd0;
            word_acc_next = '0;
            phase_next    = PH_TRAILER;
          end
          OP_SELECTDB: begin
            length_purpose_next = LP_DROP;
            phase_next          = PH_LEN_FIRST;
          end
          OP_EXPIRY: begin
            word_idx_next = 3'd0;
            word_acc_next = '0;
            phase_next    = PH_EXPIRY;
          end
          OP_T_STRING, OP_T_LIST, OP_T_HASH, OP_T_ZSET: begin
            case (data_byte)
              OP_T_STRING: record_type_next = KIND_STRING;
              OP_T_LIST:   record_type_next = KIND_LIST;
              OP_T_HASH:   record_type_next = KIND_HASH;
              default:     record_type_next = KIND_ZSET;
            endcase
            cur_role_next       = ROLE_KEY;
            length_purpose_next = LP_STRING;
            phase_next          = PH_LEN_FIRST;
          end
          default: begin
            err_set  = 1'b1;
            err_code = ERR_TYPE;
          end
        endcase
      end
      PH_LEN_FIRST: begin
        if (data_byte[7:6] == 2'b00) begin
          lv_new            = {56'd0, data_byte & LEN_LOW6};
          length_value_next = lv_new;
          len_done          = 1'b1;
        end else if (data_byte[7:6] == 2'b01) begin
          length_value_next = {56'd0, data_byte & LEN_LOW6};
          prefix_left_next  = 4'd1;
          phase_next        = PH_LEN_MORE;
        end else if (data_byte == LEN_32BIT || data_byte == LEN_64BIT) begin
          length_value_next = '0;
          prefix_left_next  = (data_byte == LEN_32BIT) ? 4'd4 : 4'd8;
          phase_next        = PH_LEN_MORE;
        end else begin
          err_set  = 1'b1;
          err_code = ERR_LENGTH;
        end
      end
      PH_LEN_MORE: begin
        lv_new            = {length_value[55:0], data_byte};
        length_value_next = lv_new;
        if (prefix_left != 4'd0) begin
          prefix_left_next = prefix_left - 4'd1;
        end
        if (prefix_left_next == 4'd0) begin
          len_done = 1'b1;
        end
      end
      PH_STRING: begin
        res_has          = 1'b1;
        res.event_res    = EV_BYTE;
        res.payload_byte = data_byte;
        res.string_role  = cur_role;
        res.value_kind   = record_type;
        str_left_next    = str_left - 1'b1;
        if (str_left_next == '0) begin
          res.string_last = 1'b1;
          str_done        = 1'b1;
        end
      end
      PH_EXPIRY: begin
        word_acc_next = acc_new;
        word_idx_next = word_idx + 3'd1;
        if (word_idx == 3'd7) begin
          pend_exp_next       = acc_new;
          pend_exp_valid_next = 1'b1;
          phase_next          = PH_OPCODE;
        end
      end
      PH_SCORE: begin
        word_acc_next = acc_new;
        word_idx_next = word_idx + 3'd1;
        if (word_idx == 3'd7) begin
          res_has        = 1'b1;
          res.event_res  = EV_SCORE;
          res.value_kind = record_type;
          res.score_bits = acc_new;
          elem_done      = 1'b1;
          elem_role      = ROLE_MEMBER;
        end
      end
      PH_TRAILER: begin
        word_acc_next = acc_new;
        word_idx_next = word_idx + 3'd1;
        if (word_idx == 3'd7) begin
          res_has       = 1'b1;
          res.event_res = EV_DONE;
          phase_next    = PH_HALT;
        end
      end
      default: begin
        was_halted = 1'b1;
      end
    endcase

    // a complete length: string, element count or dropped db number
    too_wide = (lv_new >> COUNT_BITS) != 64'd0;
    if (len_done) begin
      unique case (length_purpose)
        LP_STRING: begin
          if (too_wide) begin
            err_set  = 1'b1;
            err_code = ERR_LENGTH;
          end else if (lv_new == 64'd0) begin
            res_has         = 1'b1;
            res.event_res   = EV_EMPTY;
            res.string_role = cur_role;
            res.string_last = 1'b1;
            res.value_kind  = record_type;
            str_done        = 1'b1;
          end else begin
            str_left_next = lv_new[COUNT_BITS-1:0];
            phase_next    = PH_STRING;
          end
        end
        LP_COUNT: begin
          if (too_wide) begin
            err_set  = 1'b1;
            err_code = ERR_LENGTH;
          end else if (lv_new == 64'd0) begin
            res_has        = 1'b1;
            res.event_res  = EV_REC_END;
            res.value_kind = record_type;
            rec_end        = 1'b1;
            phase_next     = PH_OPCODE;
          end else begin
            elem_left_next = lv_new[COUNT_BITS-1:0];
            unique case (record_type)
              KIND_HASH: cur_role_next = ROLE_HFIELD;
              KIND_ZSET: cur_role_next = ROLE_MEMBER;
              default:   cur_role_next = ROLE_LIST;
            endcase
            length_purpose_next = LP_STRING;
            phase_next          = PH_LEN_FIRST;
          end
        end
        default: begin
          phase_next = PH_OPCODE;
        end
      endcase
    end

    // what follows the end of a string of the current role
    if (str_done) begin
      unique case (cur_role)
        ROLE_KEY: begin
          if (record_type == KIND_STRING) begin
            cur_role_next = ROLE_VALUE;
          end
          length_purpose_next = (record_type == KIND_STRING) ? LP_STRING : LP_COUNT;
          phase_next          = PH_LEN_FIRST;
        end
        ROLE_LIST: begin
          elem_done = 1'b1;
          elem_role = ROLE_LIST;
        end
        ROLE_HFIELD: begin
          cur_role_next       = ROLE_HVALUE;
          length_purpose_next = LP_STRING;
          phase_next          = PH_LEN_FIRST;
        end
        ROLE_HVALUE: begin
          elem_done = 1'b1;
          elem_role = ROLE_HFIELD;
        end
        ROLE_MEMBER: begin
          word_idx_next = 3'd0;
          word_acc_next = '0;
          phase_next    = PH_SCORE;
        end
        default: begin
          phase_next = PH_OPCODE;
          rec_end    = 1'b1;
        end
      endcase
    end

    // one element or pair of a collection finished
    if (elem_done) begin
      elem_left_next = elem_left - 1'b1;
      if (elem_left_next == '0) begin
        phase_next = PH_OPCODE;
        rec_end    = 1'b1;
      end else begin
        cur_role_next       = elem_role;
        length_purpose_next = LP_STRING;
        phase_next          = PH_LEN_FIRST;
      end
    end

    // record end carries the pending expiry
    if (rec_end) begin
      res.record_last     = 1'b1;
      res.expiry_valid    = pend_exp_valid;
      res.expiry_ms       = pend_exp_valid ? pend_exp : 64'd0;
      pend_exp_next       = '0;
      pend_exp_valid_next = 1'b0;
    end

    // error result halts the parser
    if (err_set) begin
      res            = '0;
      res.event_res  = EV_ERROR;
      res.error_code = err_code;
      res_has        = 1'b1;
      phase_next     = PH_HALT;
    end

    // end of input: truncation error unless halted by a done or error result, then restart
    if (stream_end) begin
      if (!was_halted && phase_next != PH_HALT) begin
        res            = '0;
        res.event_res  = EV_ERROR;
        res.error_code = ERR_TRUNC;
        res_has        = 1'b1;
      end
      phase_next          = PH_HEADER;
      hdr_pos_next        = '0;
      magic_ok_next       = 1'b1;
      prefix_left_next    = '0;
      length_value_next   = '0;
      length_purpose_next = LP_DROP;
      str_left_next       = '0;
      elem_left_next      = '0;
      record_type_next    = KIND_STRING;
      cur_role_next       = ROLE_KEY;
      word_idx_next       = '0;
      word_acc_next       = '0;
      pend_exp_next       = '0;
      pend_exp_valid_next = 1'b0;
    end
  end

  // state update, one byte per fire
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      hdr_pos        <= '0;
      magic_ok       <= 1'b1;
      prefix_left    <= '0;
      length_value   <= '0;
      length_purpose <= LP_DROP;
      str_left       <= '0;
      elem_left      <= '0;
      record_type    <= KIND_STRING;
      cur_role       <= ROLE_KEY;
      word_idx       <= '0;
      word_acc       <= '0;
      pend_exp       <= '0;
      pend_exp_valid <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      hdr_pos        <= hdr_pos_next;
      magic_ok       <= magic_ok_next;
      prefix_left    <= prefix_left_next;
      length_value   <= length_value_next;
      length_purpose <= length_purpose_next;
      str_left       <= str_left_next;
      elem_left      <= elem_left_next;
      record_type    <= record_type_next;
      cur_role       <= cur_role_next;
      word_idx       <= word_idx_next;
      word_acc       <= word_acc_next;
      pend_exp       <= pend_exp_next;
      pend_exp_valid <= pend_exp_valid_next;
    end
  end

endmodule

// ===== verif/tb_snapshot_record_stream_parser_top.sv =====
// Testbench for snapshot_record_stream_parser_top: drives snapshot byte streams (directed
// corner cases, then random well-formed, broken and cut-short files) and checks each result
// field by field against an in-bench decoder. Depends on srsp_pkg and the parser RTL.
module tb_snapshot_record_stream_parser_top;
  import srsp_pkg::*;

  localparam int          HOLD_CYCLES = 200;
  localparam int          PHASE_BYTES = 60;
  localparam logic [63:0] CNT_MAX     = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS_DEF);
  // ascii magic, first byte in the top lane
  localparam logic [39:0] MAGIC_SEQ   = 40'h52_45_44_49_53;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       drain;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [2:0]  string_role;
  logic        string_last;
  logic        record_last;
  logic [1:0]  value_kind;
  logic [63:0] score_bits;
  logic        expiry_valid;
  logic [63:0] expiry_ms;
  logic [2:0]  error_code;

  snapshot_record_stream_parser_top #(
    .COUNT_BITS(COUNT_BITS_DEF)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .payload_byte (payload_byte),
    .string_role  (string_role),
    .string_last  (string_last),
    .record_last  (record_last),
    .value_kind   (value_kind),
    .score_bits   (score_bits),
    .expiry_valid (expiry_valid),
    .expiry_ms    (expiry_ms),
    .error_code   (error_code)
  );

  always #1 clk = ~clk;

  // stimulus and result bookkeeping
  stim_t      stream_bytes [$];
  logic [7:0] file_bytes [$];
  result_t    decoded_events [$];
  stim_t      cur;
  result_t    got_want;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         queued = 0;
  int         files_built = 0;
  int         bytes_taken = 0;
  int         results_seen = 0;
  int         stall_cycles = 0;
  int         fail_cnt = 0;
  int         ev_count [8];

  // decoder state
  phase_t      ph;
  logic [3:0]  hdr_pos;
  logic        magic_good;
  logic [3:0]  pfx_left;
  logic [63:0] len_val;
  lpurp_t      len_use;
  logic [63:0] str_left;
  logic [63:0] elem_left;
  logic [1:0]  rec_kind;
  logic [2:0]  role;
  logic [3:0]  word_left;
  logic [63:0] word_acc;
  logic [63:0] exp_hold;
  logic        exp_hold_valid;
  result_t     ev_out;
  logic        ev_ready;

  function automatic void reset_decoder();
    ph             = PH_HEADER;
    hdr_pos        = '0;
    magic_good     = 1'b1;
    pfx_left       = '0;
    len_val        = '0;
    len_use        = LP_DROP;
    str_left       = '0;
    elem_left      = '0;
    rec_kind       = KIND_STRING;
    role           = ROLE_KEY;
    word_left      = '0;
    word_acc       = '0;
    exp_hold       = '0;
    exp_hold_valid = 1'b0;
  endfunction

  function automatic void fail_with(input logic [2:0] code);
    ev_out            = '0;
    ev_out.event_res  = EV_ERROR;
    ev_out.error_code = code;
    ph                = PH_HALT;
    ev_ready          = 1'b1;
  endfunction

  // attach and consume the held expiry
  function automatic void close_record();
    ev_out.record_last  = 1'b1;
    ev_out.expiry_valid = exp_hold_valid;
    ev_out.expiry_ms    = exp_hold_valid ? exp_hold : 64'd0;
    exp_hold            = '0;
    exp_hold_valid      = 1'b0;
  endfunction

  function automatic void start_string(input logic [2:0] r);
    role    = r;
    len_use = LP_STRING;
    ph      = PH_LEN_FIRST;
  endfunction

  function automatic void start_word(input phase_t p);
    word_left = 4'd8;
    word_acc  = '0;
    ph        = p;
  endfunction

  function automatic logic finish_element(input logic [2:0] next_role);
    elem_left = (elem_left - 64'd1) & CNT_MAX;
    if (elem_left == 0) begin
      ph = PH_OPCODE;
      return 1'b1;
    end
    start_string(next_role);
    return 1'b0;
  endfunction

  // next step once a string of the current role is complete; 1 ends the record
  function automatic logic after_string();
    case (role)
      ROLE_KEY: begin
        if (rec_kind == KIND_STRING) begin
          start_string(ROLE_VALUE);
        end else begin
          len_use = LP_COUNT;
          ph      = PH_LEN_FIRST;
        end
        return 1'b0;
      end
      ROLE_LIST:   return finish_element(ROLE_LIST);
      ROLE_HFIELD: begin
        start_string(ROLE_HVALUE);
        return 1'b0;
      end
      ROLE_HVALUE: return finish_element(ROLE_HFIELD);
      ROLE_MEMBER: begin
        start_word(PH_SCORE);
        return 1'b0;
      end
      default: begin
        ph = PH_OPCODE;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void length_complete();
    if (len_use == LP_STRING) begin
      if (len_val > CNT_MAX) begin
        fail_with(ERR_LENGTH);
      end else if (len_val == 0) begin
        ev_out.event_res   = EV_EMPTY;
        ev_out.string_role = role;
        ev_out.string_last = 1'b1;
        ev_out.value_kind  = rec_kind;
        if (after_string()) close_record();
        ev_ready = 1'b1;
      end else begin
        str_left = len_val;
        ph       = PH_STRING;
      end
    end else if (len_use == LP_COUNT) begin
      if (len_val > CNT_MAX) begin
        fail_with(ERR_LENGTH);
      end else if (len_val == 0) begin
        ev_out.event_res  = EV_REC_END;
        ev_out.value_kind = rec_kind;
        close_record();
        ph       = PH_OPCODE;
        ev_ready = 1'b1;
      end else begin
        elem_left = len_val;
        start_string(rec_kind == KIND_HASH ? ROLE_HFIELD :
                     rec_kind == KIND_ZSET ? ROLE_MEMBER : ROLE_LIST);
      end
    end else begin
      ph = PH_OPCODE;
    end
  endfunction

  // little-endian word assembly; 1 when all eight bytes are in
  function automatic logic take_word_byte(input logic [7:0] b);
    logic [3:0] lane;
    lane     = 4'd8 - word_left;
    word_acc = word_acc | ({56'd0, b} << (8 * lane[2:0]));
    if (word_left != 0) word_left = word_left - 4'd1;
    return word_left == 0;
  endfunction

  // decode one accepted byte and queue the result it yields, if any
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic halted;
    halted   = 1'b0;
    ev_out   = '0;
    ev_ready = 1'b0;
    case (ph)
      PH_HEADER: begin
        if (hdr_pos < MAGIC_LEN && b != MAGIC_SEQ[8 * (4 - hdr_pos) +: 8]) magic_good = 1'b0;
        hdr_pos = hdr_pos + 4'd1;
        if (hdr_pos >= HEADER_LEN) begin
          if (!magic_good) fail_with(ERR_MAGIC);
          else ph = PH_OPCODE;
        end
      end
      PH_OPCODE: begin
        if (b == OP_EOF) begin
          start_word(PH_TRAILER);
        end else if (b == OP_SELECTDB) begin
          len_use = LP_DROP;
          ph      = PH_LEN_FIRST;
        end else if (b == OP_EXPIRY) begin
          start_word(PH_EXPIRY);
        end else if (b == OP_T_STRING || b == OP_T_LIST || b == OP_T_HASH || b == OP_T_ZSET) begin
          rec_kind = (b == OP_T_STRING) ? KIND_STRING : (b == OP_T_LIST) ? KIND_LIST :
                     (b == OP_T_HASH) ? KIND_HASH : KIND_ZSET;
          start_string(ROLE_KEY);
        end else begin
          fail_with(ERR_TYPE);
        end
      end
      PH_LEN_FIRST: begin
        if (b[7:6] == 2'b00) begin
          len_val = {58'd0, b[5:0]};
          length_complete();
        end else if (b[7:6] == 2'b01) begin
          len_val  = {58'd0, b[5:0]};
          pfx_left = 4'd1;
          ph       = PH_LEN_MORE;
        end else if (b == LEN_32BIT || b == LEN_64BIT) begin
          len_val  = '0;
          pfx_left = (b == LEN_32BIT) ? 4'd4 : 4'd8;
          ph       = PH_LEN_MORE;
        end else begin
          fail_with(ERR_LENGTH);
        end
      end
      PH_LEN_MORE: begin
        len_val = {len_val[55:0], b};
        if (pfx_left != 0) pfx_left = pfx_left - 4'd1;
        if (pfx_left == 0) length_complete();
      end
      PH_STRING: begin
        ev_out.event_res    = EV_BYTE;
        ev_out.payload_byte = b;
        ev_out.string_role  = role;
        ev_out.value_kind   = rec_kind;
        str_left = (str_left - 64'd1) & CNT_MAX;
        if (str_left == 0) begin
          ev_out.string_last = 1'b1;
          if (after_string()) close_record();
        end
        ev_ready = 1'b1;
      end
      PH_EXPIRY: begin
        if (take_word_byte(b)) begin
          exp_hold       = word_acc;
          exp_hold_valid = 1'b1;
          ph             = PH_OPCODE;
        end
      end
      PH_SCORE: begin
        if (take_word_byte(b)) begin
          ev_out.event_res  = EV_SCORE;
          ev_out.value_kind = rec_kind;
          ev_out.score_bits = word_acc;
          if (finish_element(ROLE_MEMBER)) close_record();
          ev_ready = 1'b1;
        end
      end
      PH_TRAILER: begin
        if (take_word_byte(b)) begin
          ev_out.event_res = EV_DONE;
          ph               = PH_HALT;
          ev_ready         = 1'b1;
        end
      end
      default: halted = 1'b1;
    endcase
    // end of input: unless halted, truncation overrides whatever the byte gave, then restart
    if (last) begin
      if (!halted && ph != PH_HALT) fail_with(ERR_TRUNC);
      reset_decoder();
    end
    if (ev_ready) decoded_events.push_back(ev_out);
  endfunction

  // stream building helpers
  function automatic logic [7:0] rnd_byte();
    logic [31:0] r;
    r = $urandom();
    case (r[31:29])
      3'd0:    return 8'h00;
      3'd1:    return 8'hFF;
      default: return r[7:0];
    endcase
  endfunction

  function automatic void add_len(input logic [63:0] v);
    int form;
    int i;
    if (v < 64) form = ($urandom_range(1) == 0) ? 0 : $urandom_range(3);
    else if (v < 16384) form = $urandom_range(3, 1);
    else if (v < 64'h1_0000_0000) form = $urandom_range(3, 2);
    else form = 3;
    case (form)
      0: file_bytes.push_back({2'b00, v[5:0]});
      1: begin
        file_bytes.push_back({2'b01, v[13:8]});
        file_bytes.push_back(v[7:0]);
      end
      2: begin
        file_bytes.push_back(LEN_32BIT);
        for (i = 3; i >= 0; i--) file_bytes.push_back(v[8 * i +: 8]);
      end
      default: begin
        file_bytes.push_back(LEN_64BIT);
        for (i = 7; i >= 0; i--) file_bytes.push_back(v[8 * i +: 8]);
      end
    endcase
  endfunction

  function automatic void add_str(input int n);
    add_len(64'(n));
    repeat (n) file_bytes.push_back(rnd_byte());
  endfunction

  // mostly short strings, some empty, a few long
  function automatic int str_size();
    int r;
    r = $urandom_range(19);
    if (r < 3) return 0;
    if (r < 17) return $urandom_range(6, 1);
    return $urandom_range(40, 7);
  endfunction

  function automatic void add_word();
    repeat (8) file_bytes.push_back(rnd_byte());
  endfunction

  function automatic void add_header(input logic good);
    int i;
    int bad_at;
    bad_at = good ? 5 : $urandom_range(4);
    for (i = 0; i < 5; i++) begin
      if (i == bad_at) file_bytes.push_back(MAGIC_SEQ[8 * (4 - i) +: 8] ^ (rnd_byte() | 8'h01));
      else file_bytes.push_back(MAGIC_SEQ[8 * (4 - i) +: 8]);
    end
    repeat (4) file_bytes.push_back(rnd_byte());
  endfunction

  function automatic logic [7:0] kind_opcode(input logic [1:0] kind);
    case (kind)
      KIND_STRING: return OP_T_STRING;
      KIND_LIST:   return OP_T_LIST;
      KIND_HASH:   return OP_T_HASH;
      default:     return OP_T_ZSET;
    endcase
  endfunction

  function automatic logic [7:0] odd_type();
    logic [7:0] t;
    t = rnd_byte();
    while (t == OP_T_STRING || t == OP_T_LIST || t == OP_T_HASH || t == OP_T_ZSET ||
           t == OP_EOF || t == OP_SELECTDB || t == OP_EXPIRY)
      t = rnd_byte();
    return t;
  endfunction

  // one opcode with its body; 1 when the file is broken from here on
  function automatic logic add_entry();
    int         pick;
    int         n;
    int         i;
    logic [1:0] kind;
    logic [7:0] hi;
    pick = $urandom_range(99);
    kind = 2'($urandom_range(3));
    if (pick < 14) begin
      file_bytes.push_back(OP_EXPIRY);
      add_word();
      return 1'b0;
    end else if (pick < 22) begin
      file_bytes.push_back(OP_SELECTDB);
      if ($urandom_range(3) == 0) add_len({$urandom(), $urandom()});
      else add_len(64'($urandom_range(15)));
      return 1'b0;
    end else if (pick < 25) begin
      file_bytes.push_back(odd_type());
      return 1'b1;
    end else if (pick < 28) begin
      // reserved 11xxxxxx length prefix
      file_bytes.push_back(kind_opcode(kind));
      file_bytes.push_back(8'hC0 | (rnd_byte() & LEN_LOW6));
      return 1'b1;
    end else if (pick < 30) begin
      // huge string length; the file is cut a few bytes in
      file_bytes.push_back(kind_opcode(kind));
      file_bytes.push_back(LEN_64BIT);
      hi = rnd_byte() | 8'h80;
      file_bytes.push_back(hi);
      repeat (7) file_bytes.push_back(rnd_byte());
      repeat ($urandom_range(4, 1)) file_bytes.push_back(rnd_byte());
      return 1'b1;
    end
    file_bytes.push_back(kind_opcode(kind));
    add_str(str_size());
    if (kind == KIND_STRING) begin
      add_str(str_size());
    end else begin
      n = ($urandom_range(9) < 2) ? 0 : $urandom_range(3, 1);
      add_len(64'(n));
      for (i = 0; i < n; i++) begin
        add_str(str_size());
        if (kind == KIND_HASH) add_str(str_size());
        if (kind == KIND_ZSET) add_word();
      end
    end
    return 1'b0;
  endfunction

  // move the built file to the send queue, stream_end on its last byte
  function automatic void flush_file(input logic drain);
    stim_t s;
    int    i;
    for (i = 0; i < file_bytes.size(); i++) begin
      s.b     = file_bytes[i];
      s.last  = (i == file_bytes.size() - 1);
      s.drain = drain && (i == 0);
      stream_bytes.push_back(s);
    end
    queued      = queued + file_bytes.size();
    files_built = files_built + 1;
    file_bytes.delete();
  endfunction

  function automatic void gen_file(input logic drain);
    logic       stop;
    int         nrec;
    int         i;
    int         keep;
    logic [7:0] junk;
    stop = 1'b0;
    if ($urandom_range(19) == 0) begin
      add_header(1'b0);
      file_bytes.push_back(rnd_byte());
      stop = 1'b1;
    end else begin
      add_header(1'b1);
      nrec = $urandom_range(4, 1);
      for (i = 0; i < nrec && !stop; i++) stop = add_entry();
      if (!stop) begin
        file_bytes.push_back(OP_EOF);
        add_word();
        if ($urandom_range(1) == 1) repeat ($urandom_range(3, 1)) file_bytes.push_back(rnd_byte());
      end
    end
    // cut short now and then so that stream_end lands mid-structure
    if (!stop && $urandom_range(9) == 0) begin
      keep = $urandom_range(file_bytes.size() - 1, 1);
      while (file_bytes.size() > keep) junk = file_bytes.pop_back();
    end
    flush_file(drain);
  endfunction

  function automatic void cmp(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", fname, want, got);
      fail_cnt++;
    end
  endfunction

  // sender: one transaction per accept, predicted on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(data_byte, stream_end);
        bytes_taken++;
      end
      if (in_valid && in_stall) stall_cycles++;
      if (!in_valid || !in_stall) begin
        if (stream_bytes.size() != 0 && !(stream_bytes[0].drain && decoded_events.size() != 0)
            && $urandom_range(99) >= send_idle_pct) begin
          cur = stream_bytes.pop_front();
          in_valid   <= 1'b1;
          data_byte  <= cur.b;
          stream_end <= cur.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: long hold-off on request, otherwise random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      ev_count[event_res]++;
      if (decoded_events.size() == 0) begin
        $error("unexpected result transaction: event_res %0d", event_res);
        fail_cnt++;
      end else begin
        got_want = decoded_events.pop_front();
        cmp("event_res", 64'(got_want.event_res), 64'(event_res));
        cmp("payload_byte", 64'(got_want.payload_byte), 64'(payload_byte));
        cmp("string_role", 64'(got_want.string_role), 64'(string_role));
        cmp("string_last", 64'(got_want.string_last), 64'(string_last));
        cmp("record_last", 64'(got_want.record_last), 64'(record_last));
        cmp("value_kind", 64'(got_want.value_kind), 64'(value_kind));
        cmp("score_bits", got_want.score_bits, score_bits);
        cmp("expiry_valid", 64'(got_want.expiry_valid), 64'(expiry_valid));
        cmp("expiry_ms", got_want.expiry_ms, expiry_ms);
        cmp("error_code", 64'(got_want.error_code), 64'(error_code));
      end
    end
  end

  task automatic settle();
    while (stream_bytes.size() != 0 || in_valid || decoded_events.size() != 0) @(posedge clk);
  endtask

  initial begin
    int p;
    int mark;
    reset_decoder();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: bad magic, lone end byte, unknown type byte, lone zero byte
    add_header(1'b0);
    flush_file(1'b0);
    file_bytes.push_back(8'hFF);
    flush_file(1'b0);
    add_header(1'b1);
    file_bytes.push_back(8'h02);
    file_bytes.push_back(8'h00);
    flush_file(1'b0);
    file_bytes.push_back(8'h00);
    flush_file(1'b0);
    settle();

    // random files under each idling mix
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      mark = queued;
      while (queued - mark < PHASE_BYTES) gen_file($urandom_range(9) < 3);
      settle();
    end

    // back-pressure: receiver holds off while a long string streams in
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = hold_req + 1;
    add_header(1'b1);
    file_bytes.push_back(OP_T_STRING);
    add_str(3);
    add_str(60);
    file_bytes.push_back(OP_EOF);
    add_word();
    flush_file(1'b1);
    settle();
    repeat (10) @(posedge clk);

    $display("covered %0d stream bytes in %0d streams, %0d results checked",
             bytes_taken, files_built, results_seen);
    $display("%0d errors, %0d files done, input held back for %0d cycles, %0d mismatches",
             ev_count[EV_ERROR], ev_count[EV_DONE], stall_cycles, fail_cnt);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/srsp_pkg.sv
sv/srsp_core.sv
sv/snapshot_record_stream_parser_top.sv
verif/tb_snapshot_record_stream_parser_top.sv
